FILE: rtl/pair_scan_and_patch_defines.svh
// assertion helpers used by the checker file
`ifndef PAIR_SCAN_AND_PATCH_DEFINES_SVH
`define PAIR_SCAN_AND_PATCH_DEFINES_SVH

// same-cycle implication, sampled on clk and ignored while in reset
`define PSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/psp_pkg.sv
package psp_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int CNT_OUT_BITS   = 16;

	localparam int CFG_IDX_BITS = 3;
	localparam int PAIR_BITS    = 64;
	localparam int MASK_BITS    = 32;

	localparam int WIN_BYTES  = 8;
	localparam int HELD_BYTES = WIN_BYTES - 1;
	localparam int FILL_BITS  = 3;
	localparam int GRP_N_BITS = 4;
	localparam logic [FILL_BITS-1:0] FILL_FULL        = FILL_BITS'(HELD_BYTES);
	localparam logic [FILL_BITS-1:0] SKIP_AFTER_PATCH = FILL_BITS'(HELD_BYTES);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_OLD_INT    = 3'd0,
		CFG_NEW_INT    = 3'd1,
		CFG_OLD_FLOAT  = 3'd2,
		CFG_NEW_FLOAT  = 3'd3,
		CFG_PATCH_MASK = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [PAIR_BITS-1:0] old_int;
		logic [PAIR_BITS-1:0] new_int;
		logic [PAIR_BITS-1:0] old_float;
		logic [PAIR_BITS-1:0] new_float;
		logic [MASK_BITS-1:0] mask;
	} psp_cfg_t;

	// a run of released bytes, oldest in the low byte
	typedef struct packed {
		logic [8*WIN_BYTES-1:0]  bytes;
		logic [GRP_N_BITS-1:0]   n;
		logic                    last;
		logic [CNT_OUT_BITS-1:0] pcnt;
		logic [CNT_OUT_BITS-1:0] ccnt;
	} grp_t;

endpackage

FILE: rtl/psp_front.sv
module psp_front #(
	parameter int COUNT_BITS = psp_pkg::COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  psp_pkg::psp_cfg_t cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             region_end,
	input  logic             scan_start,
	input  logic             q_full,
	output logic             q_push,
	output psp_pkg::grp_t    q_data
);

	logic [8*psp_pkg::HELD_BYTES-1:0] held_q;
	logic [psp_pkg::FILL_BITS-1:0]    fill_q;
	logic [psp_pkg::FILL_BITS-1:0]    skip_q;
	logic [COUNT_BITS-1:0]            cand_q;
	logic [COUNT_BITS-1:0]            patch_q;

	logic                          accept;
	logic                          full_pt;
	logic [8*psp_pkg::WIN_BYTES-1:0] cat;
	logic [8*psp_pkg::WIN_BYTES-1:0] win;
	logic                          do_test;
	logic                          is_int;
	logic                          is_float;
	logic                          hit;
	logic                          do_patch;
	logic [4:0]                    site;
	logic [COUNT_BITS-1:0]         cand_base;
	logic [COUNT_BITS-1:0]         patch_base;
	logic [COUNT_BITS-1:0]         cand_n;
	logic [COUNT_BITS-1:0]         patch_n;
	logic [psp_pkg::FILL_BITS-1:0] skip_n;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign full_pt  = (fill_q == psp_pkg::FILL_FULL);

	// incoming byte lands just above the bytes already held
	always_comb begin
		cat = {data_byte, held_q};
		for (int i = 0; i < psp_pkg::HELD_BYTES; i++) begin
			if (psp_pkg::FILL_BITS'(i) == fill_q)
				cat[8*i +: 8] = data_byte;
		end
	end

	always_comb begin
		cand_base  = scan_start ? '0 : cand_q;
		patch_base = scan_start ? '0 : patch_q;
		do_test    = full_pt && (skip_q == '0);
		is_int     = (cat == cfg.old_int);
		is_float   = !is_int && (cat == cfg.old_float);
		hit        = do_test && (is_int || is_float);
		site       = cand_base[4:0];
		do_patch   = hit && cfg.mask[site];
		win        = do_patch ? (is_int ? cfg.new_int : cfg.new_float) : cat;

		cand_n = cand_base;
		if (hit && cand_base != '1)
			cand_n = cand_base + 1'b1;
		patch_n = patch_base;
		if (do_patch && patch_base != '1)
			patch_n = patch_base + 1'b1;

		if (do_patch)
			skip_n = psp_pkg::SKIP_AFTER_PATCH;
		else if (full_pt && skip_q != '0)
			skip_n = skip_q - 1'b1;
		else
			skip_n = skip_q;
	end

	assign q_push       = accept && (full_pt || region_end);
	assign q_data.bytes = win;
	assign q_data.n     = region_end ? psp_pkg::GRP_N_BITS'(fill_q) + 1'b1
	                                 : psp_pkg::GRP_N_BITS'(1);
	assign q_data.last  = region_end;
	assign q_data.pcnt  = (33'(patch_n) > 33'h0_FFFF) ? 16'hFFFF : 16'(patch_n);
	assign q_data.ccnt  = (33'(cand_n) > 33'h0_FFFF) ? 16'hFFFF : 16'(cand_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			skip_q  <= '0;
			cand_q  <= '0;
			patch_q <= '0;
		end else if (accept) begin
			cand_q  <= cand_n;
			patch_q <= patch_n;
			if (region_end) begin
				fill_q <= '0;
				skip_q <= '0;
			end else if (full_pt) begin
				skip_q <= skip_n;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !region_end)
			held_q <= full_pt ? win[8*psp_pkg::WIN_BYTES-1:8] : cat[8*psp_pkg::HELD_BYTES-1:0];
	end

endmodule

FILE: rtl/psp_queue.sv
module psp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  psp_pkg::grp_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output psp_pkg::grp_t rdata
);

	psp_pkg::grp_t                 mem_q [psp_pkg::QUEUE_DEPTH];
	logic [psp_pkg::QPTR_BITS-1:0] wr_q;
	logic [psp_pkg::QPTR_BITS-1:0] rd_q;
	logic [psp_pkg::QCNT_BITS-1:0] cnt_q;

	assign full     = (cnt_q == psp_pkg::QCNT_BITS'(psp_pkg::QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

endmodule

FILE: rtl/psp_back.sv
module psp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nonempty,
	input  psp_pkg::grp_t q_data,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          out_last,
	output logic [psp_pkg::CNT_OUT_BITS-1:0] patched_count,
	output logic [psp_pkg::CNT_OUT_BITS-1:0] candidate_count
);

	psp_pkg::grp_t                  cur_q;
	logic [psp_pkg::GRP_N_BITS-1:0] left_q;
	logic                           xfer;
	logic                           take;

	assign out_valid = (left_q != '0);
	assign xfer      = out_valid && !out_stall;
	// next run loads as the final byte of this one goes out
	assign take      = (left_q == '0) || (left_q == psp_pkg::GRP_N_BITS'(1) && xfer);
	assign q_pop     = take && q_nonempty;

	assign out_byte        = cur_q.bytes[7:0];
	assign out_last        = cur_q.last && (left_q == psp_pkg::GRP_N_BITS'(1));
	assign patched_count   = cur_q.pcnt;
	assign candidate_count = cur_q.ccnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (q_pop) begin
			left_q <= q_data.n;
		end else if (xfer) begin
			left_q <= left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
		else if (xfer)
			cur_q.bytes <= {8'h00, cur_q.bytes[8*psp_pkg::WIN_BYTES-1:8]};
	end

endmodule

FILE: rtl/pair_scan_and_patch.sv
// pair_scan_and_patch: streams a memory region through, replacing 8-byte pairs
// config: write one register per cfg transfer (cfg_index, cfg_data); cfg_ready is
//   always high, write only while the block is idle
// input: one region byte per transfer (in_valid / in_stall); region_end marks the
//   last byte, scan_start clears both counters before its byte is handled
// output: one patched byte per transfer (out_valid / out_stall) with the running
//   counts; out_last marks the last byte of a region
// throughput: one byte per cycle while in_stall is low, set by the single
//   compare-and-patch step on the eight-byte window; a region end releases up to
//   eight bytes, which drain at one per cycle while out_stall is low and the input
//   keeps flowing into the four-entry queue; a byte is released by the transfer of
//   the byte seven places later or the region end, then goes through queue and cur_q
// reset: window empty, counters zero, pairs zero, patch mask all ones, no output
// receiver stall: output holds; the queue fills and then in_stall rises
module pair_scan_and_patch #(
	parameter int COUNT_BITS = psp_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [psp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [psp_pkg::PAIR_BITS-1:0]    cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        region_end,
	input  logic        scan_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [psp_pkg::CNT_OUT_BITS-1:0] patched_count,
	output logic [psp_pkg::CNT_OUT_BITS-1:0] candidate_count
);

	psp_pkg::psp_cfg_t cfg_q;
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_nonempty;
	psp_pkg::grp_t     q_wdata;
	psp_pkg::grp_t     q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.old_int   <= '0;
			cfg_q.new_int   <= '0;
			cfg_q.old_float <= '0;
			cfg_q.new_float <= '0;
			cfg_q.mask      <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				psp_pkg::CFG_OLD_INT:    cfg_q.old_int   <= cfg_data;
				psp_pkg::CFG_NEW_INT:    cfg_q.new_int   <= cfg_data;
				psp_pkg::CFG_OLD_FLOAT:  cfg_q.old_float <= cfg_data;
				psp_pkg::CFG_NEW_FLOAT:  cfg_q.new_float <= cfg_data;
				psp_pkg::CFG_PATCH_MASK: cfg_q.mask      <= cfg_data[psp_pkg::MASK_BITS-1:0];
				default: ;
			endcase
		end
	end

	psp_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.region_end (region_end),
		.scan_start (scan_start),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	psp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_rdata)
	);

	psp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_nonempty      (q_nonempty),
		.q_data          (q_rdata),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.out_last        (out_last),
		.patched_count   (patched_count),
		.candidate_count (candidate_count)
	);

endmodule

FILE: rtl/psp_checker.sv
`include "pair_scan_and_patch_defines.svh"

module psp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        out_last,
	input logic [15:0] patched_count,
	input logic [15:0] candidate_count
);

	// a stalled output transfer keeps its whole payload
	`PSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_last) && $stable(patched_count) && $stable(candidate_count), "output changed while stalled")

	// every patch is also a candidate, both saturate at the same point
	`PSP_ASSERT_NOW(a_cnt_order, out_valid, patched_count <= candidate_count, "patched count above candidate count")

	// register writes are never held off
	`PSP_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind pair_scan_and_patch psp_checker u_psp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cfg_valid       (cfg_valid),
	.cfg_ready       (cfg_ready),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.out_byte        (out_byte),
	.out_last        (out_last),
	.patched_count   (patched_count),
	.candidate_count (candidate_count)
);
